// ===== rtl/ttc_pkg.sv =====
// Shared types, widths and a helper function of the truth table input check.
package ttc_pkg;

    localparam int ROW_IDX_W = 12;   // width of a row number on the input word
    localparam int ROW_W     = 13;   // walk counters, wide enough to hold the table size
    localparam int BASE_W    = 4;
    localparam int PC_W      = 3;
    localparam int POS_W     = 2;
    localparam int DIGIT_W   = 3;
    localparam int NUM_BASES = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PARENT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FIRST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SECOND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_THIRD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FOURTH  = 3'd4;

    localparam logic [BASE_W-1:0] BASE_MIN = 4'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 4'd8;

    typedef logic [NUM_BASES-1:0][BASE_W-1:0] base_vec_t;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] pos;
    } query_cmd_t;

    typedef struct packed {
        logic valid;
        logic fict;
        logic bad;
    } query_res_t;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end else begin
            r = b;
        end
        return r;
    endfunction

endpackage

// ===== rtl/truth_table_essential_input_check_top.sv =====
// Top level: configuration registers, stream handshake, table and query sequencer.
// A row write does not hold the stream; the next word is accepted in the following cycle.
// A query first forms stride and size, where size is the product of the active bases:
// one multiplier step per active parent, then one row pair per cycle from the dual-read
// table memory. A bad position skips both and goes straight to the result.
// After reset, a clearing pass over the table marks every row unknown; no word is
// accepted meanwhile, while configuration writes are taken. Registers reset to 1, 2, 2, 2, 2.
module truth_table_essential_input_check_top
    import ttc_pkg::*;
#(
    parameter int MAX_PARENTS = 4,
    parameter int TABLE_DEPTH = 4096,
    parameter int VALUE_BITS  = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // row_index[11:0], child_value[19:12], value_unknown[20], parent_position[22:21], zero
    input  logic [23:0]           s_tdata,
    // kind[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // is_fictitious[0], bad_position[1], zero
    output logic [7:0]            m_tdata
);

    localparam int PARENT_LIM = (MAX_PARENTS < NUM_BASES) ? MAX_PARENTS : NUM_BASES;

    logic [PC_W-1:0]       pc_reg;
    base_vec_t             bases_reg;
    logic [PC_W-1:0]       active_n;
    logic                  clearing;
    logic                  walker_idle;
    logic                  accept;
    logic                  is_query;
    query_cmd_t            cmd;
    query_res_t            res;
    logic                  res_ack;
    logic                  m_valid_reg;
    logic                  fict_out_reg;
    logic                  bad_out_reg;
    logic [ROW_W-1:0]      rd_addr_a, rd_addr_b;
    logic                  rd_known_a, rd_known_b;
    logic [VALUE_BITS-1:0] rd_value_a, rd_value_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg    <= PC_W'(1);
            bases_reg <= {NUM_BASES{BASE_MIN}};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PARENT_COUNT: pc_reg       <= cfg_wdata[PC_W-1:0];
                CFG_BASE_FIRST:   bases_reg[0] <= cfg_wdata;
                CFG_BASE_SECOND:  bases_reg[1] <= cfg_wdata;
                CFG_BASE_THIRD:   bases_reg[2] <= cfg_wdata;
                CFG_BASE_FOURTH:  bases_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (pc_reg == '0) begin
            active_n = PC_W'(1);
        end else if (pc_reg > PC_W'(PARENT_LIM)) begin
            active_n = PC_W'(PARENT_LIM);
        end else begin
            active_n = pc_reg;
        end
    end

    assign s_tready  = !clearing && walker_idle;
    assign accept    = s_tvalid && s_tready;
    assign is_query  = s_tuser;
    assign cmd.start = accept && is_query;
    assign cmd.pos   = s_tdata[22:21];

    ttc_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clearing   (clearing),
        .wr_en      (accept && !is_query),
        .wr_row     (s_tdata[11:0]),
        .wr_value   (VALUE_BITS'(s_tdata[19:12])),
        .wr_known   (!s_tdata[20]),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_known_a (rd_known_a),
        .rd_known_b (rd_known_b),
        .rd_value_a (rd_value_a),
        .rd_value_b (rd_value_b)
    );

    ttc_walker #(
        .VALUE_BITS (VALUE_BITS)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .active_n   (active_n),
        .bases      (bases_reg),
        .idle       (walker_idle),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_known_a (rd_known_a),
        .rd_known_b (rd_known_b),
        .rd_value_a (rd_value_a),
        .rd_value_b (rd_value_b),
        .res        (res),
        .res_ack    (res_ack)
    );

    // The result moves into the output register as soon as the register is free.
    assign res_ack = res.valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ack) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            fict_out_reg <= res.fict;
            bad_out_reg  <= res.bad;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, bad_out_reg, fict_out_reg};

endmodule

// ===== rtl/ttc_table.sv =====
// Truth table memory: one write port, two registered read ports, clearing pass after reset.
module ttc_table
    import ttc_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int VALUE_BITS  = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    output logic                  clearing,
    input  logic                  wr_en,
    input  logic [ROW_IDX_W-1:0]  wr_row,
    input  logic [VALUE_BITS-1:0] wr_value,
    input  logic                  wr_known,
    input  logic [ROW_W-1:0]      rd_addr_a,
    input  logic [ROW_W-1:0]      rd_addr_b,
    output logic                  rd_known_a,
    output logic                  rd_known_b,
    output logic [VALUE_BITS-1:0] rd_value_a,
    output logic [VALUE_BITS-1:0] rd_value_b
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W  = ((ROW_W > ADDR_W) ? ROW_W : ADDR_W) + 1;

    // Each entry holds the known flag above the child value.
    logic [VALUE_BITS:0] mem [TABLE_DEPTH];

    logic                clear_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [CMP_W-1:0]    wr_ext, rd_ext_a, rd_ext_b;
    logic                wr_in_rng, rng_a, rng_b;
    logic                rng_a_reg, rng_b_reg;
    logic [VALUE_BITS:0] data_a_reg, data_b_reg;

    assign wr_ext    = CMP_W'(wr_row);
    assign rd_ext_a  = CMP_W'(rd_addr_a);
    assign rd_ext_b  = CMP_W'(rd_addr_b);
    assign wr_in_rng = wr_ext < CMP_W'(TABLE_DEPTH);
    assign rng_a     = rd_ext_a < CMP_W'(TABLE_DEPTH);
    assign rng_b     = rd_ext_b < CMP_W'(TABLE_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clear_reg) begin
            if (clr_cnt_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                clear_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (wr_en && wr_in_rng) begin
            mem[wr_ext[ADDR_W-1:0]] <= {wr_known, wr_value};
        end
    end

    always_ff @(posedge aclk) begin
        data_a_reg <= mem[rd_ext_a[ADDR_W-1:0]];
        data_b_reg <= mem[rd_ext_b[ADDR_W-1:0]];
        rng_a_reg  <= rng_a;
        rng_b_reg  <= rng_b;
    end

    // Rows past the depth of the memory read as unknown.
    assign clearing   = clear_reg;
    assign rd_known_a = rng_a_reg && data_a_reg[VALUE_BITS];
    assign rd_known_b = rng_b_reg && data_b_reg[VALUE_BITS];
    assign rd_value_a = data_a_reg[VALUE_BITS-1:0];
    assign rd_value_b = data_b_reg[VALUE_BITS-1:0];

endmodule

// ===== rtl/ttc_walker.sv =====
// Query sequencer: stride and size by a shared multiplier, then a pairwise table walk.
module ttc_walker
    import ttc_pkg::*;
#(
    parameter int VALUE_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  query_cmd_t            cmd,
    input  logic [PC_W-1:0]       active_n,
    input  base_vec_t             bases,
    output logic                  idle,
    output logic [ROW_W-1:0]      rd_addr_a,
    output logic [ROW_W-1:0]      rd_addr_b,
    input  logic                  rd_known_a,
    input  logic                  rd_known_b,
    input  logic [VALUE_BITS-1:0] rd_value_a,
    input  logic [VALUE_BITS-1:0] rd_value_b,
    output query_res_t            res,
    input  logic                  res_ack
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [ROW_W-1:0]     acc_reg;
    logic [ROW_W-1:0]     stride_reg;
    logic [ROW_W-1:0]     size_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     p_reg;
    logic [DIGIT_W-1:0]   last_digit_reg;
    logic [ROW_W-1:0]     r_reg;
    logic [ROW_W-1:0]     j_reg;
    logic [DIGIT_W-1:0]   d_reg;
    logic                 pend_reg;
    logic                 fict_reg;
    logic                 bad_reg;

    logic [BASE_W-1:0]        cur_base;
    logic [ROW_W+BASE_W-1:0]  product;
    logic                     issue;
    logic                     differ;

    // The one multiplier, shared by every step of the stride and size pass.
    assign cur_base = clamp_base(bases[p_reg]);
    assign product  = acc_reg * cur_base;

    assign issue  = (state_reg == ST_WALK) && (d_reg != last_digit_reg);
    assign differ = pend_reg && rd_known_a && rd_known_b && (rd_value_a != rd_value_b);

    assign rd_addr_a = r_reg;
    assign rd_addr_b = r_reg + stride_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            fict_reg  <= 1'b0;
            bad_reg   <= 1'b0;
        end else begin
            pend_reg <= issue;
            if (differ) begin
                fict_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (cmd.start) begin
                        pos_reg <= cmd.pos;
                        if (PC_W'(cmd.pos) >= active_n) begin
                            fict_reg  <= 1'b0;
                            bad_reg   <= 1'b1;
                            state_reg <= ST_DONE;
                        end else begin
                            bad_reg   <= 1'b0;
                            acc_reg   <= ROW_W'(1);
                            p_reg     <= POS_W'(active_n - 1'b1);
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    // Walk from the least significant parent up; the stride is the
                    // running product just before the queried parent joins in.
                    if (p_reg == pos_reg) begin
                        stride_reg     <= acc_reg;
                        last_digit_reg <= DIGIT_W'(cur_base - 1'b1);
                    end
                    acc_reg <= ROW_W'(product);
                    if (p_reg == '0) begin
                        size_reg  <= ROW_W'(product);
                        r_reg     <= '0;
                        j_reg     <= '0;
                        d_reg     <= '0;
                        fict_reg  <= 1'b1;
                        state_reg <= ST_WALK;
                    end else begin
                        p_reg <= p_reg - 1'b1;
                    end
                end
                ST_WALK: begin
                    r_reg <= r_reg + 1'b1;
                    if (j_reg == stride_reg - 1'b1) begin
                        j_reg <= '0;
                        d_reg <= (d_reg == last_digit_reg) ? '0 : d_reg + 1'b1;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                    if (r_reg == size_reg - 1'b1) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // The last pair is compared in this cycle.
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (res_ack) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res.valid = (state_reg == ST_DONE);
    assign res.fict  = fict_reg;
    assign res.bad   = bad_reg;

endmodule
